@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the sweep RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define DSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define DSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/core/dss_pkg.sv @@
package dss_pkg;

  localparam int MAX_GRID   = 4096;
  localparam int ADDR_W     = $clog2(MAX_GRID);
  localparam int GRID_W     = 13;
  localparam int G_W        = (GRID_W > ADDR_W + 1) ? GRID_W : ADDR_W + 1;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 32;
  localparam int ALPHA_W    = 15;
  localparam int SUM_W      = 56;
  localparam int LAP_W      = VAL_W + 3;
  localparam int PROD_W     = LAP_W + ALPHA_W + 1;
  localparam int NV_W       = VAL_W + 3;
  localparam int SHIFT      = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [VAL_W-1:0]   Q_ONE       = 32'h8000_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 15'd16384;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd66;
  localparam logic [GRID_W-1:0]  GRID_RESET  = 13'd1024;
  localparam logic [G_W-1:0]     GRID_MIN    = G_W'(3);
  localparam logic [G_W-1:0]     GRID_MAX    = G_W'(MAX_GRID);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 2'd0,
    REG_GRID_SIZE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] new_value;
    logic             sweep_done;
    logic [SUM_W-1:0] diff_sum;
  } out_word_t;

endpackage

@@ rtl/core/dss_ram.sv @@
module dss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/diffusion_stencil_sweep.sv @@
// Channel  Handshake            Word
// in       in_valid / in_stall   cell_value, frame_start (one cell, raster order)
// out      out_valid / out_stall row_index, col_index, new_value, sweep_done, diff_sum
// cfg      cfg_valid / cfg_ready register index, write data (always ready)
//
// One cell is taken every cycle unless the input stalls; the single line memory is read and
// written once per cell. A result passes the stage registers once the cell below it arrives
// and leaves through an eight-word queue. The input stalls only when queued plus in-flight
// results would overflow that queue. Synchronous active-low reset resets counters, accumulator,
// control registers and queue pointers; the line memory is not cleared and needs no sweep.
`include "assert_macros.svh"

module diffusion_stencil_sweep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dss_pkg::VAL_W-1:0]        in_cell_value,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dss_pkg::IDX_W-1:0]        out_row_index,
  output logic [dss_pkg::IDX_W-1:0]        out_col_index,
  output logic [dss_pkg::VAL_W-1:0]        out_new_value,
  output logic                             out_sweep_done,
  output logic [dss_pkg::SUM_W-1:0]        out_diff_sum,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dss_pkg::*;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             done;
    logic             clear;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  // Configuration
  logic [ALPHA_W-1:0] alpha_r;
  logic [GRID_W-1:0]  grid_size_r;
  logic [G_W-1:0]     g;
  logic [ALPHA_W-1:0] alpha_use;

  // Position and stage registers
  logic [ADDR_W-1:0]   row_r, col_r;
  logic [ADDR_W-1:0]   cur_row, cur_col, nxt_row, nxt_col;
  logic [G_W-1:0]      col_inc, row_inc;
  logic                restart, col_wrap, accept;
  logic [VAL_W-1:0]    v_sat;
  tag_t                tag_in, s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [VAL_W-1:0]    s1_v_r;
  logic [2*VAL_W-1:0]  cur_r, ram_q;
  logic [VAL_W-1:0]    left_r;
  logic [VAL_W-1:0]    above, center, right;
  logic [LAP_W-1:0]    lap_nxt;
  logic signed [LAP_W-1:0]  lap_r;
  logic [VAL_W-1:0]    s2_center_r, s3_center_r;
  logic signed [PROD_W-1:0] prod_r, shifted;
  logic signed [NV_W-1:0]   nv_s;
  logic [VAL_W-1:0]    nv, change, s4_nv_r, s4_change_r;

  // Accumulator and result queue
  logic [SUM_W-1:0]    acc_r, acc_nxt, acc_base, acc_add;
  logic [SUM_W:0]      acc_sum;
  out_word_t           fifo_r [FIFO_DEPTH];
  out_word_t           push_word;
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]    cnt_r, inflight;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (G_W'(grid_size_r) < GRID_MIN) begin
      g = GRID_MIN;
    end else if (G_W'(grid_size_r) > GRID_MAX) begin
      g = GRID_MAX;
    end else begin
      g = G_W'(grid_size_r);
    end
    alpha_use = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
  end

  // Position of the arriving cell and of the cell after it.
  always_comb begin
    v_sat   = (in_cell_value > Q_ONE) ? Q_ONE : in_cell_value;
    restart = in_frame_start || (G_W'(row_r) >= g) || (G_W'(col_r) >= g);
    cur_row = restart ? '0 : row_r;
    cur_col = restart ? '0 : col_r;
    col_inc = G_W'(cur_col) + G_W'(1);
    row_inc = G_W'(cur_row) + G_W'(1);
    col_wrap = col_inc >= g;
    nxt_col = col_wrap ? '0 : col_inc[ADDR_W-1:0];
    if (!col_wrap) begin
      nxt_row = cur_row;
    end else if (row_inc >= g) begin
      nxt_row = '0;
    end else begin
      nxt_row = row_inc[ADDR_W-1:0];
    end
    tag_in.valid = 1'b1;
    tag_in.emit  = (cur_row >= ADDR_W'(2)) && (cur_col != '0)
                   && (G_W'(cur_col) <= g - G_W'(2));
    tag_in.done  = (G_W'(cur_row) == g - G_W'(1)) && (G_W'(cur_col) == g - G_W'(2));
    tag_in.clear = (cur_row == '0) && (cur_col == '0);
    tag_in.row   = IDX_W'(cur_row - ADDR_W'(1));
    tag_in.col   = IDX_W'(cur_col);
  end

  assign accept = in_valid && !in_stall;

  // Each entry holds {row above, middle row}. The read is issued one cell ahead, so when a
  // cell's column is in stage one the memory output already shows the column to its right.
  dss_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (MAX_GRID)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_tag_r.valid),
    .waddr (s1_addr_r),
    .wdata ({cur_r[VAL_W-1:0], s1_v_r}),
    .re    (accept),
    .raddr (nxt_col),
    .rdata (ram_q)
  );

  // Stage one: five-point sum.
  always_comb begin
    above   = cur_r[2*VAL_W-1:VAL_W];
    center  = cur_r[VAL_W-1:0];
    right   = ram_q[VAL_W-1:0];
    lap_nxt = LAP_W'(above) + LAP_W'(s1_v_r) + LAP_W'(left_r) + LAP_W'(right)
              - (LAP_W'(center) << 2);
  end

  // Stage three: floor shift, clamp to [0, 1.0] and absolute change.
  always_comb begin
    shifted = prod_r >>> SHIFT;
    nv_s    = $signed({3'b000, s3_center_r}) + shifted[NV_W-1:0];
    if (nv_s < 0) begin
      nv = '0;
    end else if (nv_s > $signed({3'b000, Q_ONE})) begin
      nv = Q_ONE;
    end else begin
      nv = nv_s[VAL_W-1:0];
    end
    change = (nv >= s3_center_r) ? nv - s3_center_r : s3_center_r - nv;
  end

  // Stage four: saturating accumulation in stream order, then into the queue.
  always_comb begin
    acc_base = s4_tag_r.clear ? '0 : acc_r;
    acc_sum  = {1'b0, acc_base} + (SUM_W + 1)'(s4_change_r);
    acc_add  = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    if (!s4_tag_r.valid) begin
      acc_nxt = acc_r;
    end else if (s4_tag_r.emit) begin
      acc_nxt = acc_add;
    end else begin
      acc_nxt = acc_base;
    end
    push                 = s4_tag_r.valid && s4_tag_r.emit;
    push_word.row_index  = s4_tag_r.row;
    push_word.col_index  = s4_tag_r.col;
    push_word.new_value  = s4_nv_r;
    push_word.sweep_done = s4_tag_r.done;
    push_word.diff_sum   = s4_tag_r.done ? acc_add : '0;
  end

  assign inflight = (FIFO_AW + 1)'(s1_tag_r.emit) + (FIFO_AW + 1)'(s2_tag_r.emit)
                  + (FIFO_AW + 1)'(s3_tag_r.emit) + (FIFO_AW + 1)'(s4_tag_r.emit);
  // Stall is taken from registers alone, so every result already in flight has a slot.
  assign in_stall = (cnt_r + inflight) >= (FIFO_AW + 1)'(FIFO_DEPTH);

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign out_row_index  = fifo_r[rd_ptr_r].row_index;
  assign out_col_index  = fifo_r[rd_ptr_r].col_index;
  assign out_new_value  = fifo_r[rd_ptr_r].new_value;
  assign out_sweep_done = fifo_r[rd_ptr_r].sweep_done;
  assign out_diff_sum   = fifo_r[rd_ptr_r].diff_sum;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RESET;
      grid_size_r <= GRID_RESET;
      row_r       <= '0;
      col_r       <= '0;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
      s4_tag_r    <= '0;
      acc_r       <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ALPHA:     alpha_r     <= cfg_data[ALPHA_W-1:0];
          REG_GRID_SIZE: grid_size_r <= cfg_data[GRID_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        row_r <= nxt_row;
        col_r <= nxt_col;
      end
      s1_tag_r <= accept ? tag_in : '0;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
      acc_r    <= acc_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v_r    <= v_sat;
      s1_addr_r <= cur_col;
      cur_r     <= ram_q;
    end
    if (s1_tag_r.valid) begin
      left_r <= center;
    end
    lap_r       <= $signed(lap_nxt);
    s2_center_r <= center;
    prod_r      <= lap_r * $signed({1'b0, alpha_use});
    s3_center_r <= s2_center_r;
    s4_nv_r     <= nv;
    s4_change_r <= change;
    if (push) begin
      fifo_r[wr_ptr_r] <= push_word;
    end
  end

  `DSS_ASSERT_IMP(a_queue_credit, clk, rst_n, 1'b1, (cnt_r + inflight) <= (FIFO_AW + 1)'(FIFO_DEPTH), "result queue over-committed")
  `DSS_ASSERT_IMP(a_no_push_full, clk, rst_n, push, cnt_r < (FIFO_AW + 1)'(FIFO_DEPTH), "push into full result queue")
  `DSS_ASSERT_IMP(a_sum_only_done, clk, rst_n, out_valid && !out_sweep_done, out_diff_sum == '0, "change sum shown before the last cell")
  `DSS_ASSERT_NXT(a_write_follows, clk, rst_n, accept, s1_tag_r.valid && (s1_addr_r < ADDR_W'(MAX_GRID - 1) || s1_addr_r == ADDR_W'(MAX_GRID - 1)), "line memory write missing after accept")

endmodule
